// ----- hdl/egt_pkg.sv -----
// ----------------------------------------------------------------------------
// egt_pkg
// Shared types and constants for the escaped grouped tokenizer.
// ----------------------------------------------------------------------------
package egt_pkg;

    localparam int DEF_MAX_DIVIDERS = 4;
    localparam int DEF_MAX_GROUPS   = 4;

    // The packed registers hold four byte lanes each.
    localparam int PACK_LANES = 4;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 3;
    localparam int PACK_W     = PACK_LANES * BYTE_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [PACK_W-1:0]  RST_DIVIDER_BYTES     = 32'h000A_0920;
    localparam logic [COUNT_W-1:0] RST_DIVIDER_COUNT     = 3'd3;
    localparam logic [PACK_W-1:0]  RST_GROUP_OPEN_BYTES  = '0;
    localparam logic [PACK_W-1:0]  RST_GROUP_CLOSE_BYTES = '0;
    localparam logic [COUNT_W-1:0] RST_GROUP_COUNT       = 3'd0;
    localparam logic [BYTE_W-1:0]  RST_ESCAPE_BYTE       = 8'h5C;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVIDER_BYTES     = 3'd0,
        CFG_DIVIDER_COUNT     = 3'd1,
        CFG_GROUP_OPEN_BYTES  = 3'd2,
        CFG_GROUP_CLOSE_BYTES = 3'd3,
        CFG_GROUP_COUNT       = 3'd4,
        CFG_ESCAPE_BYTE       = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_SKIP  = 2'd0,
        MODE_TOKEN = 2'd1,
        MODE_GROUP = 2'd2
    } scan_mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_DIVIDER = 2'd1,
        KIND_END     = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic [PACK_W-1:0]  divider_bytes;
        logic [COUNT_W-1:0] divider_count;
        logic [PACK_W-1:0]  group_open_bytes;
        logic [PACK_W-1:0]  group_close_bytes;
        logic [COUNT_W-1:0] group_count;
        logic [BYTE_W-1:0]  escape_byte;
    } tok_cfg_t;

    typedef struct packed {
        logic              divider_hit;
        logic              group_hit;
        logic [BYTE_W-1:0] close_byte;
    } byte_match_t;

endpackage

// ----- hdl/egt_match.sv -----
// ----------------------------------------------------------------------------
// egt_match
// Compares one byte against the active divider and group-open lanes.
// ----------------------------------------------------------------------------
module egt_match #(
    parameter int MAX_DIVIDERS = egt_pkg::DEF_MAX_DIVIDERS,
    parameter int MAX_GROUPS   = egt_pkg::DEF_MAX_GROUPS
) (
    input  logic [egt_pkg::BYTE_W-1:0] in_byte,
    input  egt_pkg::tok_cfg_t          cfg,
    output egt_pkg::byte_match_t       match
);
    import egt_pkg::*;

    localparam int DIV_LANES = (MAX_DIVIDERS < PACK_LANES) ? MAX_DIVIDERS : PACK_LANES;
    localparam int GRP_LANES = (MAX_GROUPS < PACK_LANES) ? MAX_GROUPS : PACK_LANES;
    localparam logic [COUNT_W-1:0] DIV_CAP = COUNT_W'(DIV_LANES);
    localparam logic [COUNT_W-1:0] GRP_CAP = COUNT_W'(GRP_LANES);

    logic [COUNT_W-1:0] div_n;
    logic [COUNT_W-1:0] grp_n;

    assign div_n = (cfg.divider_count > DIV_CAP) ? DIV_CAP : cfg.divider_count;
    assign grp_n = (cfg.group_count > GRP_CAP) ? GRP_CAP : cfg.group_count;

    always_comb begin
        match = '0;
        for (int i = 0; i < DIV_LANES; i++) begin
            if ((COUNT_W'(i) < div_n) &&
                (cfg.divider_bytes[i*BYTE_W +: BYTE_W] == in_byte)) begin
                match.divider_hit = 1'b1;
            end
        end
        // Walk downward so that the lowest matching position wins.
        for (int i = GRP_LANES - 1; i >= 0; i--) begin
            if ((COUNT_W'(i) < grp_n) &&
                (cfg.group_open_bytes[i*BYTE_W +: BYTE_W] == in_byte)) begin
                match.group_hit  = 1'b1;
                match.close_byte = cfg.group_close_bytes[i*BYTE_W +: BYTE_W];
            end
        end
    end

endmodule

// ----- hdl/escaped_grouped_tokenizer.sv -----
// ----------------------------------------------------------------------------
// escaped_grouped_tokenizer
// Splits a byte stream into tokens with dividers, an escape byte and
// quoted groups.
// ----------------------------------------------------------------------------
// Each input request carries one byte on s_tdata, or an end-of-stream mark
// on s_tuser. Each output request carries a token byte, the divider that
// ended a token, or an end-of-stream mark, with its kind on m_tuser.
// Skipped dividers, escape bytes and group bytes produce no output.
// An accepted byte lands in an input register; the tokenizer state and the
// result register are then updated from it once the output side can advance.
// One request is taken every cycle while the output side keeps up; the rate
// is set by the single compare-and-update stage between the two registers.
// When the receiver stalls, the result register holds and the input stops
// taking requests once its register is full. The configuration channel is
// always ready and must only be written while the block is idle.
// Reset clears both registers' valid flags, the scan state and restores
// the default dividers (space, tab, newline) and escape byte (backslash).
// ----------------------------------------------------------------------------
module escaped_grouped_tokenizer #(
    parameter int MAX_DIVIDERS = egt_pkg::DEF_MAX_DIVIDERS,
    parameter int MAX_GROUPS   = egt_pkg::DEF_MAX_GROUPS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic [0:0]                    s_tuser,   // [0] stream_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic [1:0]                    m_tuser,   // [1:0] out_kind
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [egt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [egt_pkg::PACK_W-1:0]    cfg_data
);
    import egt_pkg::*;

    tok_cfg_t          cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;
    scan_mode_t        mode_reg, mode_next;
    logic              esc_reg, esc_next;
    logic [BYTE_W-1:0] close_reg, close_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    out_kind_t         out_kind_reg, out_kind_next;
    logic              emit;
    logic              advance;
    logic              step;
    byte_match_t       match;

    egt_match #(
        .MAX_DIVIDERS(MAX_DIVIDERS),
        .MAX_GROUPS  (MAX_GROUPS)
    ) u_match (
        .in_byte(in_byte_reg),
        .cfg    (cfg_reg),
        .match  (match)
    );

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tuser   = out_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.divider_bytes     <= RST_DIVIDER_BYTES;
            cfg_reg.divider_count     <= RST_DIVIDER_COUNT;
            cfg_reg.group_open_bytes  <= RST_GROUP_OPEN_BYTES;
            cfg_reg.group_close_bytes <= RST_GROUP_CLOSE_BYTES;
            cfg_reg.group_count       <= RST_GROUP_COUNT;
            cfg_reg.escape_byte       <= RST_ESCAPE_BYTE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIVIDER_BYTES:     cfg_reg.divider_bytes     <= cfg_data;
                CFG_DIVIDER_COUNT:     cfg_reg.divider_count     <= cfg_data[COUNT_W-1:0];
                CFG_GROUP_OPEN_BYTES:  cfg_reg.group_open_bytes  <= cfg_data;
                CFG_GROUP_CLOSE_BYTES: cfg_reg.group_close_bytes <= cfg_data;
                CFG_GROUP_COUNT:       cfg_reg.group_count       <= cfg_data[COUNT_W-1:0];
                CFG_ESCAPE_BYTE:       cfg_reg.escape_byte       <= cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SKIP;
            esc_reg   <= 1'b0;
            close_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            close_reg <= close_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_byte_reg <= out_byte_next;
            out_kind_reg <= out_kind_next;
        end
    end

    always_comb begin
        logic esc_eff;
        logic tok;
        mode_next     = mode_reg;
        esc_next      = esc_reg;
        close_next    = close_reg;
        emit          = 1'b0;
        out_byte_next = in_byte_reg;
        out_kind_next = KIND_BYTE;
        esc_eff       = esc_reg;
        tok           = 1'b0;
        if (in_end_reg) begin
            emit          = 1'b1;
            out_byte_next = '0;
            out_kind_next = KIND_END;
            mode_next     = MODE_SKIP;
            esc_next      = 1'b0;
            close_next    = '0;
        end else begin
            unique case (mode_reg)
                MODE_GROUP: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        emit     = 1'b1;
                    end else if (in_byte_reg == cfg_reg.escape_byte) begin
                        esc_next = 1'b1;
                    end else if (in_byte_reg == close_reg) begin
                        mode_next = MODE_TOKEN;
                    end else begin
                        emit = 1'b1;
                    end
                end
                MODE_TOKEN: begin
                    tok = 1'b1;
                end
                default: begin
                    if (!match.divider_hit) begin
                        mode_next = MODE_TOKEN;
                        esc_eff   = 1'b0;
                        tok       = 1'b1;
                    end
                end
            endcase
            if (tok) begin
                if (esc_eff) begin
                    esc_next = 1'b0;
                    emit     = 1'b1;
                end else if (in_byte_reg == cfg_reg.escape_byte) begin
                    esc_next = 1'b1;
                end else if (match.divider_hit) begin
                    mode_next     = MODE_SKIP;
                    esc_next      = 1'b0;
                    emit          = 1'b1;
                    out_kind_next = KIND_DIVIDER;
                end else if (match.group_hit) begin
                    mode_next  = MODE_GROUP;
                    esc_next   = 1'b0;
                    close_next = match.close_byte;
                end else begin
                    esc_next = 1'b0;
                    emit     = 1'b1;
                end
            end
        end
    end

endmodule
